FILE: rtl/utf8_name_readability_check_assert.svh
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef UTF8_NAME_READABILITY_CHECK_ASSERT_SVH
`define UTF8_NAME_READABILITY_CHECK_ASSERT_SVH

// Same-cycle implication.
`define U8NR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U8NR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/u8nr_pkg.sv
package u8nr_pkg;

    localparam int CP_W = 21;

    // ASCII limits
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_DEL   = 8'h7F;

    // Blacklisted code point ranges
    localparam logic [CP_W-1:0] COMB_LO  = 21'h000300;
    localparam logic [CP_W-1:0] COMB_HI  = 21'h00036F;
    localparam logic [CP_W-1:0] HEBAR_LO = 21'h000591;
    localparam logic [CP_W-1:0] HEBAR_HI = 21'h0006FF;
    localparam logic [CP_W-1:0] ZW_LO    = 21'h00200B;
    localparam logic [CP_W-1:0] ZW_HI    = 21'h00200F;
    localparam logic [CP_W-1:0] BIDI_LO  = 21'h00202A;
    localparam logic [CP_W-1:0] BIDI_HI  = 21'h00206F;
    localparam logic [CP_W-1:0] PUA_LO   = 21'h00E000;
    localparam logic [CP_W-1:0] PUA_HI   = 21'h00F8FF;
    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

    // Decoder state carried between bytes
    typedef struct packed {
        logic            failed;
        logic [1:0]      pending;
        logic [CP_W-1:0] accum;
        logic            seen_any;
    } dec_state_t;

    // Per-byte outcome from the classifier
    typedef struct packed {
        dec_state_t nxt;
        logic       term;
        logic       readable;
    } step_t;

endpackage

FILE: rtl/u8nr_byte_if.sv
interface u8nr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;

    modport source (output valid, output name_byte, input ready);
    modport sink   (input valid, input name_byte, output ready);
endinterface

FILE: rtl/u8nr_verdict_if.sv
interface u8nr_verdict_if;
    logic valid;
    logic ready;
    logic readable;

    modport source (output valid, output readable, input ready);
    modport sink   (input valid, input readable, output ready);
endinterface

FILE: rtl/u8nr_classify.sv
module u8nr_classify (
    input  logic [7:0]          name_byte,
    input  u8nr_pkg::dec_state_t cur,
    output u8nr_pkg::step_t     step
);

    function automatic logic blacklisted(input logic [u8nr_pkg::CP_W-1:0] cp);
        return (cp >= u8nr_pkg::COMB_LO  && cp <= u8nr_pkg::COMB_HI)  ||
               (cp >= u8nr_pkg::HEBAR_LO && cp <= u8nr_pkg::HEBAR_HI) ||
               (cp >= u8nr_pkg::ZW_LO    && cp <= u8nr_pkg::ZW_HI)    ||
               (cp >= u8nr_pkg::BIDI_LO  && cp <= u8nr_pkg::BIDI_HI)  ||
               (cp >= u8nr_pkg::PUA_LO   && cp <= u8nr_pkg::PUA_HI)   ||
               (cp == u8nr_pkg::REPL_CHAR);
    endfunction

    logic [u8nr_pkg::CP_W-1:0] shifted;

    // accumulator with the next six payload bits appended
    assign shifted = {cur.accum[u8nr_pkg::CP_W-7:0], name_byte[5:0]};

    always_comb
    begin
        step.nxt      = cur;
        step.term     = (name_byte == 8'h00);
        step.readable = cur.seen_any && !cur.failed && (cur.pending == 2'd0);

        if (step.term)
        begin
            // terminator: verdict out, everything clears
            step.nxt = '0;
        end
        else
        begin
            step.nxt.seen_any = 1'b1;
            if (!cur.failed)
            begin
                if (cur.pending == 2'd0)
                begin
                    // lead byte
                    if (!name_byte[7])
                    begin
                        if (name_byte < u8nr_pkg::ASCII_SPACE ||
                            name_byte == u8nr_pkg::ASCII_DEL)
                        begin
                            step.nxt.failed = 1'b1;
                        end
                    end
                    else if (name_byte[7:5] == 3'b110)
                    begin
                        step.nxt.accum   = {16'd0, name_byte[4:0]};
                        step.nxt.pending = 2'd1;
                    end
                    else if (name_byte[7:4] == 4'b1110)
                    begin
                        step.nxt.accum   = {17'd0, name_byte[3:0]};
                        step.nxt.pending = 2'd2;
                    end
                    else if (name_byte[7:3] == 5'b11110)
                    begin
                        step.nxt.accum   = {18'd0, name_byte[2:0]};
                        step.nxt.pending = 2'd3;
                    end
                    else
                    begin
                        step.nxt.failed = 1'b1;
                    end
                end
                else if (name_byte[7:6] != 2'b10)
                begin
                    // bad continuation
                    step.nxt.failed  = 1'b1;
                    step.nxt.pending = 2'd0;
                    step.nxt.accum   = '0;
                end
                else
                begin
                    step.nxt.pending = cur.pending - 2'd1;
                    step.nxt.accum   = shifted;
                    if (cur.pending == 2'd1)
                    begin
                        // sequence complete: check the code point
                        if (blacklisted(shifted))
                        begin
                            step.nxt.failed = 1'b1;
                        end
                        step.nxt.accum = '0;
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/u8nr_out_reg.sv
module u8nr_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  readable_in,
    output logic                  can_load,
    u8nr_verdict_if.source        verdict
);

    logic valid_reg;
    logic readable_reg;

    // free when empty or the held verdict transfers this cycle
    assign can_load = !valid_reg || verdict.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            readable_reg <= readable_in;
        end
    end

    assign verdict.valid    = valid_reg;
    assign verdict.readable = readable_reg;

endmodule

FILE: rtl/utf8_name_readability_check.sv
// A terminator moves from the input register into the output register, which loads its verdict,
// provided the output register is free or its verdict transfers in that cycle.
// Throughput: one byte per cycle; the per-byte decode is a single registered step.
// A verdict held at the output stalls a following terminator and the bytes behind it.
// Reset (rst_n low, asynchronous): input stage, decoder state and output
// register empty and cleared.
`include "utf8_name_readability_check_assert.svh"

module utf8_name_readability_check (
    input  logic           clk,
    input  logic           rst_n,
    u8nr_byte_if.sink      name_chan,
    u8nr_verdict_if.source verdict
);

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    u8nr_pkg::dec_state_t state_reg;
    u8nr_pkg::step_t      step;
    logic                 can_load;
    logic                 adv;
    logic                 term_go;
    logic                 term_stall;

    // classify the held byte against the current state
    u8nr_classify u_classify (
        .name_byte (byte_reg),
        .cur       (state_reg),
        .step      (step)
    );

    // a terminator needs room in the output register; other bytes always move
    assign adv             = in_valid_reg && (!step.term || can_load);
    assign name_chan.ready = !in_valid_reg || adv;

    // terminator moving on, or waiting for the output register
    assign term_go    = adv && step.term;
    assign term_stall = in_valid_reg && step.term && !can_load;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (name_chan.ready)
        begin
            in_valid_reg <= name_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_chan.ready && name_chan.valid)
        begin
            byte_reg <= name_chan.name_byte;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (adv)
        begin
            state_reg <= step.nxt;
        end
    end

    u8nr_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (term_go),
        .readable_in (step.readable),
        .can_load    (can_load),
        .verdict     (verdict)
    );

    `U8NR_ASSERT_NXT(a_verdict_follows_term, term_go, verdict.valid, "terminator gave no verdict")
    `U8NR_ASSERT_NXT(a_state_clears_on_term, term_go, state_reg == '0, "state not cleared")
    `U8NR_ASSERT_IMP(a_failed_no_pending, state_reg.failed, state_reg.pending == 2'd0, "pending")
    `U8NR_ASSERT_IMP(a_idle_accum_zero, state_reg.pending == 2'd0, state_reg.accum == '0, "accum")
    `U8NR_ASSERT_NXT(a_term_held_on_stall, term_stall, in_valid_reg && $stable(byte_reg), "lost")

endmodule
